FILE: sv/prime_test_and_next_prime_top_assert.svh
// ----------------------------------------------------------------------------
// prime test and next prime - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef PRIME_TEST_AND_NEXT_PRIME_TOP_ASSERT_SVH
`define PRIME_TEST_AND_NEXT_PRIME_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PTNP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PTNP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ptnp_pkg.sv
// ----------------------------------------------------------------------------
// ptnp_pkg
// Types and constants shared by the prime test and next prime block.
// ----------------------------------------------------------------------------
package ptnp_pkg;

    // default width of the number under test
    localparam int C_VALUE_BITS = 31;

    // first trial divisor and its square
    localparam int C_FIRST_DIV    = 3;
    localparam int C_FIRST_DIV_SQ = 9;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BOUND,
        ST_DIV,
        ST_STEP,
        ST_OUT
    } t_state;

    // which number is being tested
    typedef enum logic {
        PH_VALUE,
        PH_NEXT
    } t_phase;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // take the input value as the number under test
        logic init_d;     // reset trial divisor to three
        logic start_div;  // launch a remainder computation
        logic adv_d;      // move to the next trial divisor
        logic inc_n;      // step the number under test upward
        logic set_isp;    // record the verdict on the input value
        logic isp_bit;
        logic set_next;   // record the current number as next prime
        logic next_zero;  // no prime fits, record zero
        logic out_load;   // copy results into the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic small_prime;  // number is two or three
        logic le_one;       // number is zero or one
        logic even;
        logic sq_gt_n;      // divisor squared exceeds the number
        logic n_is_max;     // number is all ones
        logic div_done;
        logic rem_zero;
    } t_stat;

endpackage

FILE: sv/prime_test_and_next_prime_top.sv
// ----------------------------------------------------------------------------
// prime_test_and_next_prime_top
// Primality test of one number and search for the next prime above it.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one number per transfer in tdata. m_axis returns one
//   result per number: bit 0 is the primality of the number, the bits above
//   it hold the smallest prime strictly greater (zero when none fits).
//   Numbers are tested by 6k-1 / 6k+1 trial division in a bit-serial
//   remainder unit; an even or trivially small candidate is settled
//   without a division.
//   One number is worked on at a time; s_axis_tready is high only while the
//   block waits for a number. The finished result sits in an output
//   register, so a new number is taken while m_axis waits on a stall; a
//   second result waits inside until the first transfer completes.
//   Reset (synchronous, active low) drops any item in flight and clears the
//   output valid.
// ----------------------------------------------------------------------------
module prime_test_and_next_prime_top #(
    parameter int VALUE_BITS = ptnp_pkg::C_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: value
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: is_prime, next_prime
    output logic [((VALUE_BITS + 8) / 8) * 8-1:0] m_axis_tdata
);
    import ptnp_pkg::*;

    localparam int IN_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((VALUE_BITS + 8) / 8) * 8;

    t_cmd  w_cmd;
    t_stat w_stat;

    ptnp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .o_in_tready  (s_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    ptnp_dp #(
        .VALUE_BITS (VALUE_BITS),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_tdata (s_axis_tdata),
        .o_stat  (w_stat),
        .o_tdata (m_axis_tdata)
    );

endmodule

FILE: sv/ptnp_div.sv
// ----------------------------------------------------------------------------
// ptnp_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptnp_div #(
    parameter int VALUE_BITS = ptnp_pkg::C_VALUE_BITS,
    parameter int DIV_BITS   = (ptnp_pkg::C_VALUE_BITS + 1) / 2 + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [DIV_BITS-1:0]   i_divisor,
    output logic                  o_done,
    output logic                  o_rem_zero
);
    import ptnp_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [CW-1:0]         r_cnt;
    logic                  r_done;
    logic [VALUE_BITS-1:0] r_q;
    logic [DIV_BITS-1:0]   r_rem;
    logic [DIV_BITS-1:0]   r_dsr;
    logic [DIV_BITS:0]     n_trial;
    logic [DIV_BITS:0]     n_diff;
    logic [DIV_BITS-1:0]   n_rem;

    // shift in next dividend bit and subtract when it fits
    always_comb begin
        n_trial = {r_rem, r_q[VALUE_BITS-1]};
        n_diff  = n_trial - {1'b0, r_dsr};
        if (n_trial >= {1'b0, r_dsr}) begin
            n_rem = n_diff[DIV_BITS-1:0];
        end else begin
            n_rem = n_trial[DIV_BITS-1:0];
        end
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(VALUE_BITS);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // partial remainder and dividend shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[VALUE_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule

FILE: sv/ptnp_dp.sv
// ----------------------------------------------------------------------------
// ptnp_dp
// Datapath: number under test, trial divisor and square, result registers.
// ----------------------------------------------------------------------------
module ptnp_dp #(
    parameter int VALUE_BITS = ptnp_pkg::C_VALUE_BITS,
    parameter int IN_W       = ((ptnp_pkg::C_VALUE_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((ptnp_pkg::C_VALUE_BITS + 8) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ptnp_pkg::t_cmd   i_cmd,
    input  logic [IN_W-1:0]  i_tdata,
    output ptnp_pkg::t_stat  o_stat,
    output logic [OUT_W-1:0] o_tdata
);
    import ptnp_pkg::*;

    localparam int DW = (VALUE_BITS + 1) / 2 + 2;
    localparam int SW = VALUE_BITS + 2;

    logic [VALUE_BITS-1:0] r_n;
    logic [DW-1:0]         r_d;
    logic [SW-1:0]         r_sq;
    logic                  r_first;
    logic                  r_step4;
    logic                  r_isp;
    logic [VALUE_BITS-1:0] r_next;
    logic                  r_o_isp;
    logic [VALUE_BITS-1:0] r_o_next;
    logic [SW-1:0]         n_sq;
    logic [DW-1:0]         n_d;
    logic                  w_div_done;
    logic                  w_rem_zero;

    // number under test
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_tdata[VALUE_BITS-1:0];
        end else if (i_cmd.inc_n) begin
            r_n <= r_n + 1'b1;
        end
    end

    // next divisor of the 6k-1 / 6k+1 walk, square kept by addition
    always_comb begin
        if (r_step4 && !r_first) begin
            n_d  = r_d + DW'(4);
            n_sq = r_sq + SW'({r_d, 3'b000}) + SW'(16);
        end else begin
            n_d  = r_d + DW'(2);
            n_sq = r_sq + SW'({r_d, 2'b00}) + SW'(4);
        end
    end

    // trial divisor registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_d) begin
            r_d     <= DW'(C_FIRST_DIV);
            r_sq    <= SW'(C_FIRST_DIV_SQ);
            r_first <= 1'b1;
            r_step4 <= 1'b0;
        end else if (i_cmd.adv_d) begin
            r_d     <= n_d;
            r_sq    <= n_sq;
            r_first <= 1'b0;
            r_step4 <= r_first ? 1'b0 : !r_step4;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_isp) begin
            r_isp <= i_cmd.isp_bit;
        end
        if (i_cmd.set_next) begin
            r_next <= r_n;
        end else if (i_cmd.next_zero) begin
            r_next <= '0;
        end
        if (i_cmd.out_load) begin
            r_o_isp  <= r_isp;
            r_o_next <= r_next;
        end
    end

    // remainder unit
    ptnp_div #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_done     (w_div_done),
        .o_rem_zero (w_rem_zero)
    );

    // status to controller
    always_comb begin
        o_stat.small_prime = (r_n == VALUE_BITS'(2)) || (r_n == VALUE_BITS'(3));
        o_stat.le_one      = (r_n[VALUE_BITS-1:1] == '0);
        o_stat.even        = !r_n[0];
        o_stat.sq_gt_n     = (r_sq > SW'(r_n));
        o_stat.n_is_max    = &r_n;
        o_stat.div_done    = w_div_done;
        o_stat.rem_zero    = w_rem_zero;
    end

    assign o_tdata = OUT_W'({r_o_next, r_o_isp});

endmodule

FILE: sv/ptnp_ctrl.sv
// ----------------------------------------------------------------------------
// ptnp_ctrl
// Controller: sequences the value test, the upward search and the output.
// ----------------------------------------------------------------------------
module ptnp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_tvalid,
    output logic            o_in_tready,
    output logic            o_out_tvalid,
    input  logic            i_out_tready,
    input  ptnp_pkg::t_stat i_stat,
    output ptnp_pkg::t_cmd  o_cmd
);
    import ptnp_pkg::*;

    t_state r_state;
    t_state n_state;
    t_phase r_phase;
    t_phase n_phase;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_vr_valid;
    logic   w_vr_prime;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_tvalid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_out_tready;

    // verdict on the number under test
    always_comb begin
        w_vr_valid = 1'b0;
        w_vr_prime = 1'b0;
        case (r_state)
            ST_CHECK: begin
                w_vr_valid = i_stat.small_prime || i_stat.le_one || i_stat.even;
                w_vr_prime = i_stat.small_prime;
            end
            ST_BOUND: begin
                w_vr_valid = i_stat.sq_gt_n;
                w_vr_prime = 1'b1;
            end
            ST_DIV: begin
                w_vr_valid = i_stat.div_done && i_stat.rem_zero;
                w_vr_prime = 1'b0;
            end
            default: begin
                w_vr_valid = 1'b0;
                w_vr_prime = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CHECK;
                    n_phase = PH_VALUE;
                end
            end
            ST_CHECK, ST_BOUND, ST_DIV: begin
                if (w_vr_valid) begin
                    if (r_phase == PH_NEXT && w_vr_prime) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_STEP;
                    end
                end else if (r_state == ST_CHECK) begin
                    n_state = ST_BOUND;
                end else if (r_state == ST_BOUND) begin
                    n_state = ST_DIV;
                end else if (i_stat.div_done) begin
                    n_state = ST_BOUND;
                end
            end
            ST_STEP: begin
                if (i_stat.n_is_max) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_CHECK;
                    n_phase = PH_NEXT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = w_accept;
        o_cmd.init_d    = (r_state == ST_CHECK) && !w_vr_valid;
        o_cmd.start_div = (r_state == ST_BOUND) && !w_vr_valid;
        o_cmd.adv_d     = (r_state == ST_DIV) && i_stat.div_done && !i_stat.rem_zero;
        o_cmd.set_isp   = w_vr_valid && (r_phase == PH_VALUE);
        o_cmd.isp_bit   = w_vr_prime;
        o_cmd.set_next  = w_vr_valid && w_vr_prime && (r_phase == PH_NEXT);
        o_cmd.inc_n     = (r_state == ST_STEP) && !i_stat.n_is_max;
        o_cmd.next_zero = (r_state == ST_STEP) && i_stat.n_is_max;
        o_cmd.out_load  = (r_state == ST_OUT) && w_out_free;
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_VALUE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_tready  = (r_state == ST_IDLE);
    assign o_out_tvalid = r_out_valid;

endmodule

FILE: sv/ptnp_check.sv
// ----------------------------------------------------------------------------
// ptnp_check
// Port-level checker for the prime test and next prime block.
// ----------------------------------------------------------------------------
`include "prime_test_and_next_prime_top_assert.svh"

module ptnp_check #(
    parameter int VALUE_BITS = ptnp_pkg::C_VALUE_BITS
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((VALUE_BITS + 8) / 8) * 8-1:0] m_axis_tdata
);
    import ptnp_pkg::*;

    // stalled result stays offered
    `PTNP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // stalled result keeps its payload
    `PTNP_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

    // a reported next prime is odd, two, or the no-prime code
    `PTNP_ASSERT_NOW(a_next_odd, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[1] || (m_axis_tdata[VALUE_BITS:1] == VALUE_BITS'(2)) || (m_axis_tdata[VALUE_BITS:1] == '0), "next prime is even")

    // a result never appears the cycle right after a number is taken
    `PTNP_ASSERT_NXT(a_min_latency, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result too early")

endmodule

bind prime_test_and_next_prime_top ptnp_check #(
    .VALUE_BITS (VALUE_BITS)
) u_ptnp_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/prime_test_and_next_prime_top_tb.sv
// ----------------------------------------------------------------------------
// prime_test_and_next_prime_top_tb
// Stream-level test of the primality test and next-prime search block. Each
// number sent is predicted by trial division in the bench. Every returned
// result is compared field by field, in order. The run covers a directed set
// of small numbers, boundary numbers and the top of the range, then a random
// mix that is weighted toward small numbers so the run stays short. The
// sender works in random bursts and the receiver stalls in its own pattern,
// including one long hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_test_and_next_prime_top_tb;

    localparam int VBITS = ptnp_pkg::C_VALUE_BITS;
    localparam int IN_W  = ((VBITS + 7) / 8) * 8;
    localparam int OUT_W = ((VBITS + 8) / 8) * 8;

    localparam int NUM_RANDOM   = 76;
    localparam int HOLD_AT      = 30;    // random item index that starts the hold-off
    localparam int HOLD_SPAN    = 12;    // small items sent while the receiver holds off
    localparam int HOLD_CYCLES  = 2000;
    localparam int DRAIN_CYCLES = 200;

    localparam logic [VBITS-1:0] VALUE_MAX = {{(VBITS - 1){1'b1}}, 1'b0};

    // receiver stall modes
    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE
    } rx_mode_t;

    typedef struct packed {
        logic             is_prime;
        logic [VBITS-1:0] next_prime;
    } prime_answer_t;

    // ------------------------------------------------------------------------
    // answer checker: predicts the answer for each number taken in and
    // compares each returned result against the oldest pending answer
    // ------------------------------------------------------------------------
    class prime_answer_checker;
        prime_answer_t expected_answers[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        // 6k +/- 1 trial division, square formed in 64 bits
        function bit is_prime_num(longint unsigned n);
            longint unsigned d;
            if (n == 2 || n == 3) return 1'b1;
            if (n <= 1 || (n % 2) == 0 || (n % 3) == 0) return 1'b0;
            for (d = 5; d * d <= n; d += 6) begin
                if ((n % d) == 0 || (n % (d + 2)) == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        // smallest prime above v that fits, zero when none does
        function logic [VBITS-1:0] next_prime_above(longint unsigned v);
            longint unsigned all_ones;
            longint unsigned c;
            all_ones = (longint'(1) << VBITS) - 1;
            c = v;
            while (c < all_ones) begin
                c++;
                if (is_prime_num(c)) return c[VBITS-1:0];
            end
            return '0;
        endfunction

        function void note_value(logic [VBITS-1:0] value);
            prime_answer_t ans;
            ans.is_prime   = is_prime_num(longint'(value));
            ans.next_prime = next_prime_above(longint'(value));
            expected_answers.push_back(ans);
        endfunction

        function void check_answer(logic [OUT_W-1:0] data);
            prime_answer_t want;
            logic          got_prime;
            logic [VBITS-1:0] got_next;
            got_prime = data[0];
            got_next  = data[VBITS:1];
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result, actual is_prime=%0d next_prime=%0d",
                         $time, got_prime, got_next);
                errors++;
                return;
            end
            want = expected_answers.pop_front();
            if (got_prime !== want.is_prime) begin
                $display("%0t: is_prime mismatch, expected %0d actual %0d",
                         $time, want.is_prime, got_prime);
                errors++;
            end
            if (got_next !== want.next_prime) begin
                $display("%0t: next_prime mismatch, expected %0d actual %0d",
                         $time, want.next_prime, got_next);
                errors++;
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    prime_answer_checker answers;
    bit                  hold_req;
    bit                  hold_done;

    prime_test_and_next_prime_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // reset held low from the start, then released on a falling edge
    initial begin
        i_rst_n = 1'b0;
        answers = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sample both transfers at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                answers.note_value(s_axis_tdata[VBITS-1:0]);
            if (m_axis_tvalid && m_axis_tready)
                answers.check_answer(m_axis_tdata);
        end
    end

    // offer one number and hold it until the transfer; leaves tvalid high
    task automatic send_value(input logic [VBITS-1:0] value);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(value);
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // mostly small numbers so the long searches stay rare
    function automatic logic [VBITS-1:0] pick_value(input int idx);
        int r;
        if (idx >= HOLD_AT && idx < HOLD_AT + HOLD_SPAN) return VBITS'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 80) return VBITS'($urandom_range(4095));
        if (r < 95) return VBITS'($urandom_range(65535));
        if (r < 99) return VBITS'($urandom_range((1 << 20) - 1));
        return VBITS'($urandom_range((1 << 24) - 1));
    endfunction

    // receiver stall pattern, with one long hold-off on request
    initial begin
        rx_mode_t mode;
        int       len;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        wait (i_rst_n);
        forever begin
            mode = rx_mode_t'($urandom_range(2));
            len  = $urandom_range(1, 40);
            repeat (len) begin
                @(negedge i_clk);
                if (hold_req && !hold_done) begin
                    hold_done = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                end else begin
                    case (mode)
                        RX_ALWAYS: m_axis_tready <= 1'b1;
                        RX_HALF:   m_axis_tready <= ($urandom_range(1) == 1);
                        default:   m_axis_tready <= ($urandom_range(3) == 0);
                    endcase
                end
            end
        end
    end

    // stimulus, drain and verdict
    initial begin
        logic [VBITS-1:0] directed[$];
        int               idx;
        int               burst;
        int               gap;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_req      = 1'b0;

        // trivial values, small primes and squares, gaps and range ends
        directed = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 23, 24, 25, 35, 49, 89, 113,
                     121, 143, 1000, 32767, 65535, 65536, VALUE_MAX};

        wait (i_rst_n);
        @(negedge i_clk);

        foreach (directed[i])
            send_value(directed[i]);
        idle_sender(5);

        // random bursts with random gaps
        idx = 0;
        while (idx < NUM_RANDOM) begin
            burst = $urandom_range(1, 10);
            for (int b = 0; b < burst && idx < NUM_RANDOM; b++) begin
                if (idx == HOLD_AT) hold_req = 1'b1;
                send_value(pick_value(idx));
                idx++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) idle_sender(gap);
        end
        s_axis_tvalid <= 1'b0;

        while (answers.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (answers.errors == 0 && answers.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #30000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/ptnp_pkg.sv
sv/ptnp_div.sv
sv/ptnp_dp.sv
sv/ptnp_ctrl.sv
sv/prime_test_and_next_prime_top.sv
sv/ptnp_check.sv
test/prime_test_and_next_prime_top_tb.sv
